>>> rtl/core/rti_pkg.sv
// rti_pkg: shared widths, register indexes and beat types for the ray/triangle unit
// depends on nothing; used by ray_triangle_intersect_unit
package rti_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIST_WIDTH    = 31;
    localparam int NUM_CFG       = 6;
    localparam int CFG_IDX_W     = 3;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vert_a_x;
        logic signed [COORD_WIDTH-1:0] vert_a_y;
        logic signed [COORD_WIDTH-1:0] vert_a_z;
        logic signed [COORD_WIDTH-1:0] vert_b_x;
        logic signed [COORD_WIDTH-1:0] vert_b_y;
        logic signed [COORD_WIDTH-1:0] vert_b_z;
        logic signed [COORD_WIDTH-1:0] vert_c_x;
        logic signed [COORD_WIDTH-1:0] vert_c_y;
        logic signed [COORD_WIDTH-1:0] vert_c_z;
    } tri_in_t;

    typedef struct packed {
        logic                  hit;
        logic [DIST_WIDTH-1:0] hit_distance;
    } tri_out_t;

endpackage

>>> rtl/core/ray_triangle_intersect_unit.sv
// ray_triangle_intersect_unit: exact fixed-point moller-trumbore ray/triangle test
// depends on rti_pkg (widths, register indexes, beat types)
//
// result: a triangle taken at a clock edge reaches done through the arithmetic, quotient and output stages
// throughput: one triangle per cycle, start is always taken (busy stays low)
// stages: 8 for edges, cross products, dot products and tests, 31 for the restoring
//   quotient (one bit a stage), 1 output register; the results cannot be held off
// reset: rst_n clears the ray registers to zero and empties the pipeline at once
module ray_triangle_intersect_unit #(
    parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rti_pkg::tri_in_t                    triangle,
    output logic                                done,
    output rti_pkg::tri_out_t                   result,
    input  logic                                cfg_wr_en,
    input  logic [rti_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rti_pkg::COORD_WIDTH-1:0]     cfg_data
);

    localparam int W     = rti_pkg::COORD_WIDTH;
    localparam int QW    = rti_pkg::DIST_WIDTH;
    localparam int DFW   = W + 1;          // vertex differences
    localparam int PW    = 2 * DFW;        // one cross product term
    localparam int CW    = PW + 1;         // cross product component
    localparam int H     = DFW + 1;        // low slice of a cross component
    localparam int HIW   = CW - H;         // high (signed) slice
    localparam int LOPW  = DFW + H + 1;    // partial product on the low slice
    localparam int HIPW  = DFW + HIW;      // partial product on the high slice
    localparam int DPW   = DFW + CW;       // one dot product term
    localparam int DW    = DPW + 2;        // sum of three terms
    localparam int RW    = DW + QW + FRAC_BITS; // divider remainder
    localparam int LATENCY = 8 + QW + 1;

    // dot product slots
    localparam int DOT_DET = 0;
    localparam int DOT_UN  = 1;
    localparam int DOT_VN  = 2;
    localparam int DOT_TN  = 3;

    // pipeline never pushes back
    assign busy = 1'b0;

    // ray registers
    logic signed [W-1:0] cfg_reg [rti_pkg::NUM_CFG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rti_pkg::NUM_CFG; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en && (cfg_index < rti_pkg::CFG_IDX_W'(rti_pkg::NUM_CFG)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    logic in_beat;
    assign in_beat = start && !busy;

    // valid bits of the arithmetic stages
    logic [8:1] sv_reg;

    // stage 1: edges and origin offset
    logic signed [DFW-1:0] s1_d_reg  [3];
    logic signed [DFW-1:0] s1_e1_reg [3];
    logic signed [DFW-1:0] s1_e2_reg [3];
    logic signed [DFW-1:0] s1_tv_reg [3];

    logic signed [W-1:0] va [3];
    logic signed [W-1:0] vb [3];
    logic signed [W-1:0] vc [3];

    always_comb
    begin
        va[0] = triangle.vert_a_x;
        va[1] = triangle.vert_a_y;
        va[2] = triangle.vert_a_z;
        vb[0] = triangle.vert_b_x;
        vb[1] = triangle.vert_b_y;
        vb[2] = triangle.vert_b_z;
        vc[0] = triangle.vert_c_x;
        vc[1] = triangle.vert_c_y;
        vc[2] = triangle.vert_c_z;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_d_reg[i]  <= DFW'(cfg_reg[rti_pkg::CFG_DIR_X + rti_pkg::CFG_IDX_W'(i)]);
            s1_e1_reg[i] <= DFW'(vb[i]) - DFW'(va[i]);
            s1_e2_reg[i] <= DFW'(vc[i]) - DFW'(va[i]);
            s1_tv_reg[i] <= DFW'(cfg_reg[rti_pkg::CFG_ORIGIN_X + rti_pkg::CFG_IDX_W'(i)])
                          - DFW'(va[i]);
        end
    end

    // stage 2: cross product terms, p = d x e2, q = tv x e1
    logic signed [PW-1:0]  s2_pp_reg [3][2];
    logic signed [PW-1:0]  s2_qp_reg [3][2];
    logic signed [DFW-1:0] s2_d_reg  [3];
    logic signed [DFW-1:0] s2_e1_reg [3];
    logic signed [DFW-1:0] s2_e2_reg [3];
    logic signed [DFW-1:0] s2_tv_reg [3];

    // stage 3: cross components
    logic signed [CW-1:0]  s3_p_reg  [3];
    logic signed [CW-1:0]  s3_q_reg  [3];
    logic signed [DFW-1:0] s3_d_reg  [3];
    logic signed [DFW-1:0] s3_e1_reg [3];
    logic signed [DFW-1:0] s3_e2_reg [3];
    logic signed [DFW-1:0] s3_tv_reg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_ff @(posedge clk)
        begin
            s2_pp_reg[i][0] <= PW'(s1_d_reg[J]) * PW'(s1_e2_reg[K]);
            s2_pp_reg[i][1] <= PW'(s1_d_reg[K]) * PW'(s1_e2_reg[J]);
            s2_qp_reg[i][0] <= PW'(s1_tv_reg[J]) * PW'(s1_e1_reg[K]);
            s2_qp_reg[i][1] <= PW'(s1_tv_reg[K]) * PW'(s1_e1_reg[J]);
            s2_d_reg[i]     <= s1_d_reg[i];
            s2_e1_reg[i]    <= s1_e1_reg[i];
            s2_e2_reg[i]    <= s1_e2_reg[i];
            s2_tv_reg[i]    <= s1_tv_reg[i];

            s3_p_reg[i]  <= CW'(s2_pp_reg[i][0]) - CW'(s2_pp_reg[i][1]);
            s3_q_reg[i]  <= CW'(s2_qp_reg[i][0]) - CW'(s2_qp_reg[i][1]);
            s3_d_reg[i]  <= s2_d_reg[i];
            s3_e1_reg[i] <= s2_e1_reg[i];
            s3_e2_reg[i] <= s2_e2_reg[i];
            s3_tv_reg[i] <= s2_tv_reg[i];
        end
    end

    // stage 4: dot product partials, the wide operand cut in a low and high slice
    // det = e1.p, u = tv.p, v = d.q, t = e2.q
    logic signed [DFW-1:0]  dot_a [4][3];
    logic signed [CW-1:0]   dot_b [4][3];
    logic signed [LOPW-1:0] s4_lo_reg [4][3];
    logic signed [HIPW-1:0] s4_hi_reg [4][3];
    logic signed [DPW-1:0]  s5_prod_reg [4][3];
    logic signed [DW-1:0]   s6_sum_reg [4];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dot_a[DOT_DET][i] = s3_e1_reg[i];
            dot_b[DOT_DET][i] = s3_p_reg[i];
            dot_a[DOT_UN][i]  = s3_tv_reg[i];
            dot_b[DOT_UN][i]  = s3_p_reg[i];
            dot_a[DOT_VN][i]  = s3_d_reg[i];
            dot_b[DOT_VN][i]  = s3_q_reg[i];
            dot_a[DOT_TN][i]  = s3_e2_reg[i];
            dot_b[DOT_TN][i]  = s3_q_reg[i];
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_dot
        for (genvar i = 0; i < 3; i++)
        begin : g_term
            always_ff @(posedge clk)
            begin
                s4_lo_reg[k][i] <= LOPW'(dot_a[k][i])
                                 * LOPW'($signed({1'b0, dot_b[k][i][H-1:0]}));
                s4_hi_reg[k][i] <= HIPW'(dot_a[k][i])
                                 * HIPW'($signed(dot_b[k][i][CW-1:H]));
                // stage 5: join the slices
                s5_prod_reg[k][i] <= (DPW'(s4_hi_reg[k][i]) <<< H) + DPW'(s4_lo_reg[k][i]);
            end
        end

        // stage 6: sum of the three terms
        always_ff @(posedge clk)
        begin
            s6_sum_reg[k] <= DW'(s5_prod_reg[k][0]) + DW'(s5_prod_reg[k][1])
                           + DW'(s5_prod_reg[k][2]);
        end
    end

    // stage 7: sign normalisation so that det is not negative
    logic signed [DW-1:0] s7_det_reg;
    logic signed [DW-1:0] s7_un_reg;
    logic signed [DW-1:0] s7_vn_reg;
    logic signed [DW-1:0] s7_tn_reg;
    logic                 s7_nz_reg;
    logic                 det_neg;

    assign det_neg = s6_sum_reg[DOT_DET][DW-1];

    always_ff @(posedge clk)
    begin
        s7_nz_reg  <= (s6_sum_reg[DOT_DET] != '0);
        s7_det_reg <= det_neg ? -s6_sum_reg[DOT_DET] : s6_sum_reg[DOT_DET];
        s7_un_reg  <= det_neg ? -s6_sum_reg[DOT_UN]  : s6_sum_reg[DOT_UN];
        s7_vn_reg  <= det_neg ? -s6_sum_reg[DOT_VN]  : s6_sum_reg[DOT_VN];
        s7_tn_reg  <= det_neg ? -s6_sum_reg[DOT_TN]  : s6_sum_reg[DOT_TN];
    end

    // stage 8 (divider slot 0): inclusive bounds, saturation check, divider set-up
    logic [RW-1:0] dv_rem_reg [QW+1];
    logic [DW-1:0] dv_det_reg [QW+1];
    logic [QW-1:0] dv_quo_reg [QW+1];
    logic          dv_hit_reg [QW+1];
    logic          dv_sat_reg [QW+1];
    logic [QW:1]   dv_valid_reg;

    logic          un_ok;
    logic          vn_ok;
    logic          tn_ok;
    logic [RW-1:0] rem_init;

    always_comb
    begin
        un_ok    = !s7_un_reg[DW-1] && (s7_un_reg <= s7_det_reg);
        vn_ok    = !s7_vn_reg[DW-1]
                && (((DW+1)'(s7_un_reg) + (DW+1)'(s7_vn_reg)) <= (DW+1)'(s7_det_reg));
        tn_ok    = !s7_tn_reg[DW-1];
        rem_init = RW'($unsigned(s7_tn_reg)) << FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0] <= rem_init;
        dv_det_reg[0] <= $unsigned(s7_det_reg);
        dv_quo_reg[0] <= '0;
        dv_hit_reg[0] <= s7_nz_reg && un_ok && vn_ok && tn_ok;
        dv_sat_reg[0] <= rem_init >= (RW'($unsigned(s7_det_reg)) << QW);
    end

    // restoring divider, one quotient bit a stage, msb first
    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        localparam int B = QW - j;

        logic [RW-1:0] div_sub;
        logic          div_ge;
        logic [QW-1:0] div_quo;

        always_comb
        begin
            div_sub    = RW'(dv_det_reg[j-1]) << B;
            div_ge     = dv_rem_reg[j-1] >= div_sub;
            div_quo    = dv_quo_reg[j-1];
            div_quo[B] = div_ge;
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j]    <= div_ge ? (dv_rem_reg[j-1] - div_sub) : dv_rem_reg[j-1];
            dv_det_reg[j]    <= dv_det_reg[j-1];
            dv_quo_reg[j]    <= div_quo;
            dv_hit_reg[j]    <= dv_hit_reg[j-1];
            dv_sat_reg[j]    <= dv_sat_reg[j-1];
        end
    end

    // output register: one beat per done strobe
    logic              done_reg;
    rti_pkg::tri_out_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg.hit <= dv_hit_reg[QW];
        if (!dv_hit_reg[QW])
        begin
            result_reg.hit_distance <= '0;
        end
        else if (dv_sat_reg[QW])
        begin
            result_reg.hit_distance <= rti_pkg::DIST_MAX;
        end
        else
        begin
            result_reg.hit_distance <= dv_quo_reg[QW];
        end
    end

    // valid bits travel alongside the data, no stall anywhere
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg       <= '0;
            dv_valid_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            sv_reg       <= {sv_reg[7:1], in_beat};
            dv_valid_reg <= {dv_valid_reg[QW-1:1], sv_reg[8]};
            done_reg     <= dv_valid_reg[QW];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> ##LATENCY done)
        else $error("result beat missing after fixed latency");

    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.hit_distance == '0))
        else $error("miss beat carries a distance");

    a_sat_max : assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[QW] && dv_hit_reg[QW] && dv_sat_reg[QW])
            |=> (result.hit_distance == rti_pkg::DIST_MAX))
        else $error("saturated distance not clamped");

    a_zero_det_miss : assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg[7] && !s7_nz_reg) |=> !dv_hit_reg[0])
        else $error("zero determinant flagged as hit");
`endif

endmodule
